/* design/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, codes and helpers for the pointer motion shaper.
// ----------------------------------------------------------------------------
package pms_pkg;

  // Mode codes carried with each item.
  localparam logic [1:0] OP_POINTER = 2'd0;
  localparam logic [1:0] OP_SCROLL  = 2'd1;
  localparam logic [1:0] OP_VOLUME  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GAIN_H    = 2'd0;
  localparam logic [1:0] CFG_GAIN_V    = 2'd1;
  localparam logic [1:0] CFG_ACCEL_DIS = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] GAIN_H_RESET = 16'd1311;
  localparam logic [15:0] GAIN_V_RESET = 16'd2185;

  // Volume step in sensor counts.
  localparam int VOLUME_STEP = 18;

  // One captured input item.
  typedef struct packed {
    logic [1:0]        op;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic signed [7:0] wheel_h_in;
    logic signed [7:0] wheel_v_in;
  } item_t;

  // One result item, first field in the top bits so it packs straight into tdata.
  typedef struct packed {
    logic              volume_down;
    logic              volume_up;
    logic signed [7:0] wheel_v_out;
    logic signed [7:0] wheel_h_out;
    logic signed [7:0] out_y;
    logic signed [7:0] out_x;
  } result_t;

  // Clamp an 11-bit signed value to the symmetric range -127..127.
  function automatic logic signed [7:0] sat8(input logic signed [10:0] v);
    logic signed [7:0] r;
    if (v > 11'sd127) begin
      r = 8'sd127;
    end else if (v < -11'sd127) begin
      r = -8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

/* design/pms_pointer.sv */
// ----------------------------------------------------------------------------
// pms_pointer
// Speed-dependent pointer gain: 1, 1.5 or 2.5 chosen from |dx|+|dy|.
// ----------------------------------------------------------------------------
module pms_pointer (
  input  logic              accel_disable,
  input  logic signed [7:0] dx,
  input  logic signed [7:0] dy,
  output logic signed [7:0] out_x,
  output logic signed [7:0] out_y
);

  logic [8:0]         abs_x;
  logic [8:0]         abs_y;
  logic [8:0]         mag;
  logic [2:0]         mul;
  logic signed [10:0] prod_x;
  logic signed [10:0] prod_y;
  logic signed [10:0] rnd_x;
  logic signed [10:0] rnd_y;
  logic signed [10:0] half_x;
  logic signed [10:0] half_y;

  // Motion magnitude as the sum of absolute deltas.
  always_comb begin
    abs_x = dx[7] ? (9'd0 - {dx[7], dx}) : {dx[7], dx};
    abs_y = dy[7] ? (9'd0 - {dy[7], dy}) : {dy[7], dy};
    mag   = abs_x + abs_y;
  end

  // Gain in halves: 2 is unity, 3 is 1.5, 5 is 2.5.
  always_comb begin
    mul = 3'd2;
    if (!accel_disable) begin
      if (mag > 9'd5) begin
        mul = 3'd5;
      end else if (mag > 9'd3) begin
        mul = 3'd3;
      end
    end
  end

  // Scale and halve, truncating toward zero, then clamp.
  always_comb begin
    prod_x = $signed({{3{dx[7]}}, dx}) * $signed({8'd0, mul});
    prod_y = $signed({{3{dy[7]}}, dy}) * $signed({8'd0, mul});
    rnd_x  = prod_x + $signed({10'd0, prod_x[10]});
    rnd_y  = prod_y + $signed({10'd0, prod_y[10]});
    half_x = {rnd_x[10], rnd_x[10:1]};
    half_y = {rnd_y[10], rnd_y[10:1]};
    out_x  = pms_pkg::sat8(half_x);
    out_y  = pms_pkg::sat8(half_y);
  end

endmodule

/* design/pms_scroll_axis.sv */
// ----------------------------------------------------------------------------
// pms_scroll_axis
// One scroll axis: Q8.16 accumulator fed through a Q0.16 gain, integer part
// emitted and removed, signed fraction kept.
// ----------------------------------------------------------------------------
module pms_scroll_axis (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic signed [7:0] d,
  input  logic [15:0]       gain,
  output logic signed [7:0] whole
);

  // Only the fraction survives between items, so 17 signed bits suffice.
  logic signed [16:0] acc_r;
  logic signed [16:0] acc_nxt;
  logic signed [24:0] prod;
  logic signed [24:0] sum;
  logic [24:0]        mag;
  logic [8:0]         whole_mag;
  logic signed [10:0] whole_s;

  // Multiply-accumulate and split into integer and fraction by magnitude.
  always_comb begin
    prod      = $signed({{17{d[7]}}, d}) * $signed({9'd0, gain});
    sum       = $signed({{8{acc_r[16]}}, acc_r}) + prod;
    mag       = sum[24] ? (25'd0 - sum) : sum;
    whole_mag = mag[24:16];
    acc_nxt   = sum[24] ? $signed(17'd0 - {1'b0, mag[15:0]}) : $signed({1'b0, mag[15:0]});
    whole_s   = sum[24] ? $signed(11'd0 - {2'b0, whole_mag}) : $signed({2'b0, whole_mag});
    whole     = pms_pkg::sat8(whole_s);
  end

  // Accumulator update on each scroll item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en) begin
      acc_r <= acc_nxt;
    end
  end

  // The kept fraction stays strictly inside one unit.
  assert property (@(posedge clk) disable iff (!rst_n) acc_r != 17'h10000)
    else $error("scroll fraction reached minus one");

endmodule

/* design/pms_volume.sv */
// ----------------------------------------------------------------------------
// pms_volume
// Volume control: counts vertical motion and pulses once per full step.
// ----------------------------------------------------------------------------
module pms_volume (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic signed [7:0] dy,
  output logic              volume_up,
  output logic              volume_down
);

  localparam logic signed [8:0] STEP = 9'(pms_pkg::VOLUME_STEP);

  // Count stays within one step either way between items.
  logic signed [5:0] acc_r;
  logic signed [5:0] acc_nxt;
  logic signed [8:0] sum;

  // Add the delta and check both thresholds.
  always_comb begin
    sum         = $signed({{3{acc_r[5]}}, acc_r}) + $signed({dy[7], dy});
    volume_down = sum >= STEP;
    volume_up   = sum <= -STEP;
    acc_nxt     = (volume_up || volume_down) ? 6'sd0 : sum[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en) begin
      acc_r <= acc_nxt;
    end
  end

  // The stored count never reaches a full step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r < 6'sd18) && (acc_r > -6'sd18))
    else $error("volume count out of range");

endmodule

/* design/pointer_motion_shaper_top.sv */
// ----------------------------------------------------------------------------
// pointer_motion_shaper_top
// Trackpad report shaper: pointer acceleration, scroll and volume modes.
// ----------------------------------------------------------------------------
// Each report is captured in an input register, shaped by one pass of
// logic and held in an output register before it is delivered, and a
// new report can be taken every cycle unless the output stalls; the path
// between the registers is one 8 x 17 multiply-accumulate per scroll
// axis. Scroll and volume accumulators update as a report moves to the
// output register. The configuration port is always ready and should
// only be written while no report is in flight.
// ----------------------------------------------------------------------------
module pointer_motion_shaper_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input reports.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // dx, dy, wheel_h_in, wheel_v_in
  input  logic [1:0]  in_tuser,   // op
  // Shaped reports.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_x, out_y, wheel_h_out, wheel_v_out,
                                  // volume_up, volume_down, zero fill
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]       gain_h_r;
  logic [15:0]       gain_v_r;
  logic              accel_dis_r;
  pms_pkg::item_t    s1_item_r;
  logic              s1_valid_r;
  pms_pkg::result_t  out_res_r;
  logic              out_valid_r;
  pms_pkg::result_t  res_nxt;
  logic              fire;
  logic              in_acc;
  logic signed [7:0] ptr_x;
  logic signed [7:0] ptr_y;
  logic signed [7:0] scr_h;
  logic signed [7:0] scr_v;
  logic              vol_up;
  logic              vol_down;
  logic              scroll_en;
  logic              volume_en;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_h_r    <= pms_pkg::GAIN_H_RESET;
      gain_v_r    <= pms_pkg::GAIN_V_RESET;
      accel_dis_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pms_pkg::CFG_GAIN_H:    gain_h_r    <= cfg_data;
        pms_pkg::CFG_GAIN_V:    gain_v_r    <= cfg_data;
        pms_pkg::CFG_ACCEL_DIS: accel_dis_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the item advances when the output register is free or draining.
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_acc || (s1_valid_r && !fire);
      out_valid_r <= fire || (out_valid_r && !out_tready);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.op         <= in_tuser;
      s1_item_r.dx         <= in_tdata[7:0];
      s1_item_r.dy         <= in_tdata[15:8];
      s1_item_r.wheel_h_in <= in_tdata[23:16];
      s1_item_r.wheel_v_in <= in_tdata[31:24];
    end
  end

  // Mode units.
  assign scroll_en = fire && (s1_item_r.op == pms_pkg::OP_SCROLL);
  assign volume_en = fire && (s1_item_r.op == pms_pkg::OP_VOLUME);

  pms_pointer u_pointer (
    .accel_disable (accel_dis_r),
    .dx            (s1_item_r.dx),
    .dy            (s1_item_r.dy),
    .out_x         (ptr_x),
    .out_y         (ptr_y)
  );

  pms_scroll_axis u_scroll_h (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (scroll_en),
    .d     (s1_item_r.dx),
    .gain  (gain_h_r),
    .whole (scr_h)
  );

  pms_scroll_axis u_scroll_v (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (scroll_en),
    .d     (s1_item_r.dy),
    .gain  (gain_v_r),
    .whole (scr_v)
  );

  pms_volume u_volume (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (volume_en),
    .dy          (s1_item_r.dy),
    .volume_up   (vol_up),
    .volume_down (vol_down)
  );

  // Result selection by mode; wheel values pass through clamped by default.
  always_comb begin
    res_nxt.out_x       = 8'sd0;
    res_nxt.out_y       = 8'sd0;
    res_nxt.wheel_h_out = pms_pkg::sat8({{3{s1_item_r.wheel_h_in[7]}}, s1_item_r.wheel_h_in});
    res_nxt.wheel_v_out = pms_pkg::sat8({{3{s1_item_r.wheel_v_in[7]}}, s1_item_r.wheel_v_in});
    res_nxt.volume_up   = 1'b0;
    res_nxt.volume_down = 1'b0;
    unique case (s1_item_r.op)
      pms_pkg::OP_SCROLL: begin
        res_nxt.wheel_h_out = scr_h;
        res_nxt.wheel_v_out = 8'sd0 - scr_v;
      end
      pms_pkg::OP_VOLUME: begin
        res_nxt.volume_up   = vol_up;
        res_nxt.volume_down = vol_down;
      end
      default: begin
        res_nxt.out_x = ptr_x;
        res_nxt.out_y = ptr_y;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r};

  // A report never asks for volume up and down together.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.volume_up && out_res_r.volume_down))
    else $error("both volume pulses set");

  // A volume pulse only comes with zeroed motion.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.volume_up || out_res_r.volume_down)) |->
      (out_res_r.out_x == 8'sd0 && out_res_r.out_y == 8'sd0))
    else $error("volume pulse with pointer motion");

  // An advancing item is presented at the output in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) fire |=> out_valid_r)
    else $error("advanced item lost");

endmodule

/* test/pms_report_checker.sv */
// ----------------------------------------------------------------------------
// pms_report_checker
// Watches the shaper's channels, predicts each report and compares it.
// ----------------------------------------------------------------------------
// Every accepted input item is run through a behavioral copy of the shaper
// (pointer acceleration, scroll accumulators, volume counter) that keeps its
// own register and accumulator state. The shaped report it produces waits in
// a queue until the block delivers a report, which is then compared field by
// field against the oldest waiting one. Register writes seen on the
// configuration port update the local register copies.
// ----------------------------------------------------------------------------
module pms_report_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          outstanding,
  output int          reports_checked,
  output int          volume_pulses
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Q16_ONE     = 65536;
  localparam int WHEEL_LIMIT = 127;

  // Local copies of the registers and the accumulators.
  logic [15:0]        gain_h;
  logic [15:0]        gain_v;
  logic               accel_dis;
  logic signed [24:0] scroll_h_q;
  logic signed [24:0] scroll_v_q;
  logic signed [20:0] vol_count;

  pms_pkg::result_t owed_reports[$];
  int               mismatches;
  int               checked;
  int               pulses;

  function automatic logic signed [7:0] clip127(input int v);
    if (v > WHEEL_LIMIT) begin
      return 8'sd127;
    end else if (v < -WHEEL_LIMIT) begin
      return -8'sd127;
    end
    return v[7:0];
  endfunction

  // Shapes one report and advances the accumulators.
  function automatic pms_pkg::result_t shape_report(input pms_pkg::item_t it);
    pms_pkg::result_t r;
    int dx, dy, mag, halves, sum_h, sum_v, whole_h, whole_v, vol;
    dx = $signed(it.dx);
    dy = $signed(it.dy);
    r = '0;
    r.wheel_h_out = clip127($signed(it.wheel_h_in));
    r.wheel_v_out = clip127($signed(it.wheel_v_in));
    case (it.op)
      pms_pkg::OP_VOLUME: begin
        vol = $signed(vol_count) + dy;
        if (vol >= pms_pkg::VOLUME_STEP) begin
          r.volume_down = 1'b1;
          vol = 0;
        end else if (vol <= -pms_pkg::VOLUME_STEP) begin
          r.volume_up = 1'b1;
          vol = 0;
        end
        vol_count = 21'(vol);
      end
      pms_pkg::OP_SCROLL: begin
        // Q8.16 accumulate, integer part leaves, signed fraction stays.
        sum_h = $signed(scroll_h_q) + dx * int'(gain_h);
        sum_v = $signed(scroll_v_q) + dy * int'(gain_v);
        whole_h = sum_h / Q16_ONE;
        whole_v = sum_v / Q16_ONE;
        scroll_h_q = 25'(sum_h - whole_h * Q16_ONE);
        scroll_v_q = 25'(sum_v - whole_v * Q16_ONE);
        r.wheel_h_out = clip127(whole_h);
        r.wheel_v_out = -clip127(whole_v);
      end
      default: begin
        // Pointer mode, the unused op included; gain counted in halves.
        halves = 2;
        if (!accel_dis) begin
          mag = ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
          if (mag > 5) begin
            halves = 5;
          end else if (mag > 3) begin
            halves = 3;
          end
        end
        r.out_x = clip127((dx * halves) / 2);
        r.out_y = clip127((dy * halves) / 2);
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    pms_pkg::item_t   it;
    pms_pkg::result_t want;
    pms_pkg::result_t got;
    if (!rst_n) begin
      gain_h     = pms_pkg::GAIN_H_RESET;
      gain_v     = pms_pkg::GAIN_V_RESET;
      accel_dis  = 1'b0;
      scroll_h_q = '0;
      scroll_v_q = '0;
      vol_count  = '0;
      owed_reports.delete();
    end else begin
      // Delivered report against the oldest prediction.
      if (out_tvalid && out_tready) begin
        got = pms_pkg::result_t'(out_tdata[33:0]);
        if (owed_reports.size() == 0) begin
          mismatches++;
          $display("%0t: report with nothing expected, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          want = owed_reports.pop_front();
          check_field("out_x", want.out_x, got.out_x);
          check_field("out_y", want.out_y, got.out_y);
          check_field("wheel_h_out", want.wheel_h_out, got.wheel_h_out);
          check_field("wheel_v_out", want.wheel_v_out, got.wheel_v_out);
          check_field("volume_up", 8'(want.volume_up), 8'(got.volume_up));
          check_field("volume_down", 8'(want.volume_down), 8'(got.volume_down));
          check_field("zero fill", 8'd0, 8'(out_tdata[39:34]));
          checked++;
        end
      end
      // Accepted input item.
      if (in_tvalid && in_tready) begin
        it.op         = in_tuser;
        it.dx         = in_tdata[7:0];
        it.dy         = in_tdata[15:8];
        it.wheel_h_in = in_tdata[23:16];
        it.wheel_v_in = in_tdata[31:24];
        want = shape_report(it);
        if (want.volume_up || want.volume_down) begin
          pulses++;
        end
        owed_reports.push_back(want);
      end
      // Register write; an unused index changes nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pms_pkg::CFG_GAIN_H:    gain_h = cfg_data;
          pms_pkg::CFG_GAIN_V:    gain_v = cfg_data;
          pms_pkg::CFG_ACCEL_DIS: accel_dis = cfg_data[0];
          default: ;
        endcase
      end
    end
    fail_count      <= mismatches;
    outstanding     <= owed_reports.size();
    reports_checked <= checked;
    volume_pulses   <= pulses;
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the pointer motion shaper.
// ----------------------------------------------------------------------------
// A directed set of reports covers the acceleration thresholds, clamping,
// the unused op, wheel pass-through, scroll overflow and volume pulses.
// Random reports then run under six register settings, the gain extremes
// and both acceleration settings among them, with random gaps on the input
// side and random stalls on the output side. The checker predicts and
// compares; this module drives the block and reports the outcome.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int PHASES         = 6;
  localparam int ITEMS_PER_PHASE = 305;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int reports_checked;
  int volume_pulses;

  pointer_motion_shaper_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pms_report_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .reports_checked (reports_checked),
    .volume_pulses   (volume_pulses)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

  // Output side: short stalls, occasional long ones, and stall-free stretches.
  int ready_hold = 0;
  always @(posedge clk) begin : sink
    int r;
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(50, 200);
      end else if (r < 70) begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(0, 4);
      end else if (r < 97) begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly full-range deltas, some small ones near the acceleration steps.
  function automatic logic [7:0] pick_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'($urandom_range(0, 16) - 8);
    if (r < 24) return ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7f;
    return 8'($urandom);
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return pms_pkg::OP_POINTER;
    if (r < 65) return pms_pkg::OP_SCROLL;
    if (r < 95) return pms_pkg::OP_VOLUME;
    return OP_UNUSED;
  endfunction

  task automatic send_report(input logic [1:0] op, input int dx, input int dy,
                             input int wh, input int wv, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {wv[7:0], wh[7:0], dy[7:0], dx[7:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Let every expected report arrive before touching the registers.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int ph);
    case (ph)
      1: begin
        write_reg(pms_pkg::CFG_GAIN_H, 16'hffff);
        write_reg(pms_pkg::CFG_GAIN_V, 16'hffff);
        write_reg(pms_pkg::CFG_ACCEL_DIS, 16'd1);
      end
      2: begin
        write_reg(pms_pkg::CFG_GAIN_H, 16'd0);
        write_reg(pms_pkg::CFG_GAIN_V, 16'd0);
        write_reg(pms_pkg::CFG_ACCEL_DIS, 16'hfffe);
      end
      3: begin
        write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(pms_pkg::CFG_GAIN_H, 16'($urandom));
        write_reg(pms_pkg::CFG_GAIN_V, 16'($urandom));
        write_reg(pms_pkg::CFG_ACCEL_DIS, 16'($urandom));
      end
      4: begin
        write_reg(pms_pkg::CFG_GAIN_H, 16'd1);
        write_reg(pms_pkg::CFG_GAIN_V, 16'd1);
        write_reg(pms_pkg::CFG_ACCEL_DIS, 16'd0);
      end
      default: begin
        write_reg(pms_pkg::CFG_GAIN_H, pms_pkg::GAIN_H_RESET);
        write_reg(pms_pkg::CFG_GAIN_V, pms_pkg::GAIN_V_RESET);
        write_reg(pms_pkg::CFG_ACCEL_DIS, 16'd0);
      end
    endcase
  endtask

  // Directed reports under the reset register values.
  task automatic directed_reset_values();
    // Acceleration steps: magnitude 2, 3, 4, 5, 6, then clamping.
    send_report(pms_pkg::OP_POINTER, 1, 1, 0, 0, pick_gap());
    send_report(pms_pkg::OP_POINTER, 2, 1, 5, -5, pick_gap());
    send_report(pms_pkg::OP_POINTER, -3, 1, 0, 0, pick_gap());
    send_report(pms_pkg::OP_POINTER, 3, -2, 0, 0, pick_gap());
    send_report(pms_pkg::OP_POINTER, -5, 1, 0, 0, pick_gap());
    send_report(pms_pkg::OP_POINTER, 127, -127, 127, -127, pick_gap());
    // Deltas and wheels of -128.
    send_report(pms_pkg::OP_POINTER, -128, 0, -128, 127, pick_gap());
    send_report(pms_pkg::OP_POINTER, 0, -128, 127, -128, pick_gap());
    send_report(OP_UNUSED, 7, -9, 1, -1, pick_gap());
    // Scroll accumulation with the default gains.
    send_report(pms_pkg::OP_SCROLL, 127, -127, 9, 9, 0);
    send_report(pms_pkg::OP_SCROLL, 127, -127, 9, 9, 0);
    send_report(pms_pkg::OP_SCROLL, -128, 127, -128, -128, pick_gap());
    // Volume pulses in both directions.
    send_report(pms_pkg::OP_VOLUME, 0, 17, 3, 4, pick_gap());
    send_report(pms_pkg::OP_VOLUME, 0, 1, 0, 0, pick_gap());
    send_report(pms_pkg::OP_VOLUME, 0, -18, 0, 0, pick_gap());
    send_report(pms_pkg::OP_VOLUME, 0, -128, 0, 0, pick_gap());
    send_report(pms_pkg::OP_VOLUME, -128, 127, -128, 127, pick_gap());
    send_report(pms_pkg::OP_VOLUME, 50, -5, 0, 0, pick_gap());
  endtask

  // Directed reports under full gains with acceleration off.
  task automatic directed_extremes();
    // Second report carries an integer part of -128 out of the accumulator.
    send_report(pms_pkg::OP_SCROLL, -128, -128, 0, 0, 0);
    send_report(pms_pkg::OP_SCROLL, -128, -128, 0, 0, 0);
    send_report(pms_pkg::OP_SCROLL, 127, 127, 0, 0, pick_gap());
    send_report(pms_pkg::OP_POINTER, -128, 127, 0, 0, pick_gap());
    send_report(pms_pkg::OP_POINTER, 100, -100, 0, 0, pick_gap());
  endtask

  initial begin
    int gap;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        apply_setting(ph);
      end
      if (ph == 0) begin
        directed_reset_values();
      end else if (ph == 1) begin
        directed_extremes();
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        gap = (k >= 100 && k < 160) ? 0 : pick_gap();
        send_report(pick_op(), pick_delta(), pick_delta(), $urandom, $urandom, gap);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("summary: %0d reports checked over %0d register settings, %0d volume pulses,",
             reports_checked, PHASES, volume_pulses);
    $display("summary: gains from 0 to full scale, acceleration on and off, all modes");
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d reports never delivered", fail_count, outstanding);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
